[rtl/dtp_pkg.sv]
// shared types and constants for the decimal integer token parser
// no dependencies
package dtp_pkg;

  localparam int OUT_VALUE_BITS = 64;
  localparam int POS_BITS       = 10;
  localparam int SYM_BITS       = 8;
  localparam int DIGIT_CNT_BITS = 5;
  localparam int TDATA_BITS     = 88;

  localparam logic [SYM_BITS-1:0] CH_MINUS = 8'h2d;
  localparam logic [SYM_BITS-1:0] CH_PLUS  = 8'h2b;
  localparam logic [SYM_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [SYM_BITS-1:0] CH_NINE  = 8'h39;

  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_LONE_SIGN  = 3'd1,
    ST_BAD_SYMBOL = 3'd2,
    ST_ABOVE_MAX  = 3'd3,
    ST_BELOW_MIN  = 3'd4
  } status_t;

  // end-of-token summary handed from the accumulator to the formatter
  typedef struct packed {
    logic                      lone;
    logic                      bad;
    logic                      neg;
    logic                      too_large;
    logic [OUT_VALUE_BITS-1:0] mag;
    logic [POS_BITS-1:0]       pos;
    logic [SYM_BITS-1:0]       sym;
  } tok_sum_t;

endpackage

[rtl/decimal_integer_token_parser_top.sv]
// top level of the decimal integer token parser
// depends on dtp_pkg, dtp_accum and dtp_format
//
// usage:
//   input stream: one token character per beat on s_tdata, s_tlast on the
//   final character. an optional sign, leading zeros, then decimal digits.
//   output stream: one result beat per token, given for the beat with
//   s_tlast. m_tuser carries the status, m_tdata the value and, for an
//   invalid symbol, its position and the symbol itself.
//   throughput: one character per cycle while the output is not stalled, with no gaps between tokens.
//   the result of a token is registered in the accumulator stage, then in
//   the formatter and output register, once the final character is taken.
//   the multiply-by-ten and add on the running magnitude sets the cycle time.
//   reset: clears the token state and empties both stages; s_tready is high
//   from the first cycle after reset.
//   stall: while m_tvalid is high and m_tready low the whole pipe holds and
//   s_tready drops in the same cycle; nothing is lost or repeated.
module decimal_integer_token_parser_top import dtp_pkg::*; #(
  parameter int VALUE_WIDTH = 64,
  parameter int MAX_DIGITS  = 19,
  parameter int INDEX_WIDTH = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [SYM_BITS-1:0]   s_tdata,   // symbol
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [TDATA_BITS-1:0] m_tdata,   // value, error_position, error_symbol, zero pad
  output logic [2:0]            m_tuser    // status
);

  logic                      en;
  logic                      beat;
  logic                      sum_valid;
  tok_sum_t                  sum;
  logic [OUT_VALUE_BITS-1:0] value;
  status_t                   status;
  logic [POS_BITS-1:0]       error_position;
  logic [SYM_BITS-1:0]       error_symbol;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign beat     = s_tvalid && en;

  dtp_accum #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS),
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .beat      (beat),
    .symbol    (s_tdata),
    .last      (s_tlast),
    .sum_valid (sum_valid),
    .sum       (sum)
  );

  dtp_format #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_format (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .sum_valid      (sum_valid),
    .sum            (sum),
    .out_valid      (m_tvalid),
    .value          (value),
    .status         (status),
    .error_position (error_position),
    .error_symbol   (error_symbol)
  );

  assign m_tdata = {(TDATA_BITS - OUT_VALUE_BITS - POS_BITS - SYM_BITS)'(0),
                    error_symbol, error_position, value};
  assign m_tuser = status;

endmodule

[rtl/dtp_accum.sv]
// per-token accumulator: digit multiply-add with limit watch, sign and bad symbol capture
// depends on dtp_pkg; emits a registered token summary on the final beat
module dtp_accum import dtp_pkg::*; #(
  parameter int VALUE_WIDTH = 64,
  parameter int MAX_DIGITS  = 19,
  parameter int INDEX_WIDTH = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                beat,
  input  logic [SYM_BITS-1:0] symbol,
  input  logic                last,
  output logic                sum_valid,
  output tok_sum_t            sum
);

  localparam int PW = VALUE_WIDTH + 4;
  localparam int EW = (INDEX_WIDTH > POS_BITS) ? INDEX_WIDTH : POS_BITS;
  localparam logic [PW-1:0] LIMIT_P = PW'(1) << (VALUE_WIDTH - 1);
  localparam logic [DIGIT_CNT_BITS-1:0] DIGITS_SAT = '1;

  logic [VALUE_WIDTH-1:0]    magnitude, magnitude_next;
  logic [DIGIT_CNT_BITS-1:0] significant_digits, significant_digits_next;
  logic                      too_large, too_large_next;
  logic                      negative_sign, negative_sign_next;
  logic [INDEX_WIDTH-1:0]    token_index, token_index_next;
  logic                      bad_symbol_seen, bad_symbol_seen_next;
  logic [INDEX_WIDTH-1:0]    first_bad_index, first_bad_index_next;
  logic [SYM_BITS-1:0]       first_bad_symbol, first_bad_symbol_next;

  logic                      is_sign, is_digit, sign_slot;
  logic [3:0]                digit;
  logic [DIGIT_CNT_BITS-1:0] sig_inc;
  logic [PW-1:0]             mag_x, prod;
  logic [EW-1:0]             bad_idx_ext;
  tok_sum_t                  sum_next;

  always_comb begin
    is_sign   = (symbol == CH_PLUS) || (symbol == CH_MINUS);
    is_digit  = (symbol >= CH_ZERO) && (symbol <= CH_NINE);
    sign_slot = (token_index == '0) && is_sign;
    digit     = 4'(symbol - CH_ZERO);
    sig_inc   = (significant_digits < DIGITS_SAT) ? significant_digits + 1'b1
                                                  : significant_digits;
    mag_x     = PW'(magnitude);
    prod      = (mag_x << 3) + (mag_x << 1) + PW'(digit);

    magnitude_next          = magnitude;
    significant_digits_next = significant_digits;
    too_large_next          = too_large;
    negative_sign_next      = negative_sign;
    bad_symbol_seen_next    = bad_symbol_seen;
    first_bad_index_next    = first_bad_index;
    first_bad_symbol_next   = first_bad_symbol;
    token_index_next        = (token_index != '1) ? token_index + 1'b1 : token_index;

    if (sign_slot) begin
      negative_sign_next = (symbol == CH_MINUS);
    end else if (is_digit) begin
      // leading zeros are dropped
      if (!bad_symbol_seen && !(significant_digits == '0 && digit == 4'd0)) begin
        significant_digits_next = sig_inc;
        if (sig_inc > DIGIT_CNT_BITS'(MAX_DIGITS)) begin
          too_large_next = 1'b1;
        end else if (!too_large) begin
          if (prod > LIMIT_P) begin
            too_large_next = 1'b1;
          end else begin
            magnitude_next = prod[VALUE_WIDTH-1:0];
          end
        end
      end
    end else if (!bad_symbol_seen) begin
      bad_symbol_seen_next  = 1'b1;
      first_bad_index_next  = token_index;
      first_bad_symbol_next = symbol;
    end

    bad_idx_ext        = EW'(first_bad_index_next);
    sum_next.lone      = sign_slot && last;
    sum_next.bad       = bad_symbol_seen_next;
    sum_next.neg       = negative_sign_next;
    sum_next.too_large = too_large_next;
    sum_next.mag       = OUT_VALUE_BITS'(magnitude_next);
    sum_next.pos       = (bad_idx_ext > EW'(POS_MAX)) ? POS_MAX : bad_idx_ext[POS_BITS-1:0];
    sum_next.sym       = first_bad_symbol_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (beat && last)) begin
      magnitude          <= '0;
      significant_digits <= '0;
      too_large          <= 1'b0;
      negative_sign      <= 1'b0;
      token_index        <= '0;
      bad_symbol_seen    <= 1'b0;
      first_bad_index    <= '0;
      first_bad_symbol   <= '0;
    end else if (beat) begin
      magnitude          <= magnitude_next;
      significant_digits <= significant_digits_next;
      too_large          <= too_large_next;
      negative_sign      <= negative_sign_next;
      token_index        <= token_index_next;
      bad_symbol_seen    <= bad_symbol_seen_next;
      first_bad_index    <= first_bad_index_next;
      first_bad_symbol   <= first_bad_symbol_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (en) begin
      sum_valid <= beat && last;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= sum_next;
    end
  end

endmodule

[rtl/dtp_format.sv]
// result formatter and output register: status decode, limit check, negation
// depends on dtp_pkg
module dtp_format import dtp_pkg::*; #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      sum_valid,
  input  tok_sum_t                  sum,
  output logic                      out_valid,
  output logic [OUT_VALUE_BITS-1:0] value,
  output status_t                   status,
  output logic [POS_BITS-1:0]       error_position,
  output logic [SYM_BITS-1:0]       error_symbol
);

  localparam logic [OUT_VALUE_BITS-1:0] LIMIT_MAG = OUT_VALUE_BITS'(1) << (VALUE_WIDTH - 1);

  logic [OUT_VALUE_BITS-1:0] value_next;
  status_t                   status_next;
  logic [POS_BITS-1:0]       pos_next;
  logic [SYM_BITS-1:0]       sym_next;

  always_comb begin
    value_next  = '0;
    status_next = ST_OK;
    pos_next    = '0;
    sym_next    = '0;
    if (sum.lone) begin
      status_next = ST_LONE_SIGN;
    end else if (sum.bad) begin
      status_next = ST_BAD_SYMBOL;
      pos_next    = sum.pos;
      sym_next    = sum.sym;
    end else if (sum.neg) begin
      if (sum.too_large) begin
        status_next = ST_BELOW_MIN;
      end else begin
        value_next = '0 - sum.mag;
      end
    end else begin
      if (sum.too_large || (sum.mag == LIMIT_MAG)) begin
        status_next = ST_ABOVE_MAX;
      end else begin
        value_next = sum.mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value          <= value_next;
      status         <= status_next;
      error_position <= pos_next;
      error_symbol   <= sym_next;
    end
  end

endmodule
